FILE: src/range_flip_count_tree_unit_assert.svh
// Assertion macros for the range flip count tree unit.
`ifndef RANGE_FLIP_COUNT_TREE_UNIT_ASSERT_SVH
`define RANGE_FLIP_COUNT_TREE_UNIT_ASSERT_SVH

// An implication checked on every rising clock edge outside reset.
`define RFCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// A next-cycle implication checked outside reset.
`define RFCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rfct_pkg.sv
// ----------------------------------------------------------------------------
// rfct_pkg
// Types and constants shared by the range flip count tree unit.
// ----------------------------------------------------------------------------
package rfct_pkg;

	localparam int unsigned FIELD_W   = 11;
	localparam int unsigned MAX_CELLS = 1024;
	localparam logic [FIELD_W-1:0] SIZE_RESET = 11'd1024;

	localparam logic MODE_FLIP  = 1'b0;
	localparam logic MODE_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP,
		ST_READ,
		ST_VISIT,
		ST_PUSH_RD,
		ST_PUSH_WR,
		ST_SUM_RD,
		ST_SUM_RD2,
		ST_SUM_WR,
		ST_DONE
	} state_t;

endpackage

FILE: src/rfct_ram.sv
// ----------------------------------------------------------------------------
// rfct_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module rfct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: src/range_flip_count_tree_unit.sv
// ----------------------------------------------------------------------------
// range_flip_count_tree_unit
// Lazy segment tree over one-bit cells: range invert and range popcount.
// ----------------------------------------------------------------------------
// Usage: an input beat (mode, left_end, right_end) is taken on in_valid and
// in_ready. Mode 0 inverts the cells of the range and returns nothing; mode 1
// returns one beat on out_valid/out_ready carrying ones_count. The size is set
// through cfg_valid/cfg_ready; each write clears the whole tree.
// One item at a time, all on the single memory port: every node visited passes
// through pop, read and visit, a lazy mark pushed to both children adds a read
// and a write for each child, and on a flip every partly covered node adds two
// reads and a write to rebuild its sum. At the default size a walk visits at
// most 39 nodes, 19 of them partly covered; an empty range goes straight to done.
// After reset and after every size write a clearing pass zeroes every word of
// the node memory; no item is accepted during it.
// The result sits in an output register; while the receiver stalls, the unit
// holds it and accepts no new item until it is taken.
// ----------------------------------------------------------------------------
`include "range_flip_count_tree_unit_assert.svh"

module range_flip_count_tree_unit
	import rfct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FIELD_W-1:0] active_size,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [FIELD_W-1:0] left_end,
	input  logic [FIELD_W-1:0] right_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] ones_count
);

	// Node indexes run from 1 up to below 2*MAX_CELLS for any size <= MAX_CELLS
	// when the tree is built on the clamped span.
	localparam int unsigned DEPTH = 2 * MAX_CELLS;
	localparam int unsigned AW    = $clog2(DEPTH);
	// A flip walk keeps a return frame and a right sibling for every split on
	// its path, plus the three frames of the deepest split.
	localparam int unsigned LVL   = 2 * $clog2(MAX_CELLS) + 2;
	localparam int unsigned SW    = $clog2(LVL + 1);
	localparam int unsigned MEMW  = FIELD_W + 1;
	localparam logic [FIELD_W-1:0] MAXC = FIELD_W'(MAX_CELLS);

	typedef struct packed {
		logic [AW-1:0]      node;
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		logic               ret;
	} frame_t;

	state_t state_q, state_d;

	logic [FIELD_W-1:0] size_q;
	logic               mode_q;
	logic [FIELD_W-1:0] a_q, b_q;
	logic [FIELD_W-1:0] acc_q;
	logic [AW-1:0]      clr_q;
	frame_t             stk_q [LVL];
	logic [SW-1:0]      sp_q;
	frame_t             cur_q;
	logic [FIELD_W-1:0] ones_q;
	logic               node_pend;
	logic [FIELD_W-1:0] lsum_q;
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_q;

	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [MEMW-1:0]    mem_wdata, mem_rdata;

	rfct_ram #(.WIDTH(MEMW), .DEPTH(DEPTH)) u_node_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	logic [FIELD_W-1:0] eff_size, a_in, b_in, mid;
	logic [FIELD_W:0]   mid_sum;
	logic               covers;
	logic [AW-1:0]      lchild, rchild;
	frame_t             top;

	always_comb begin
		eff_size = size_q;
		if (size_q == '0) begin
			eff_size = FIELD_W'(1);
		end
		if (size_q > MAXC) begin
			eff_size = MAXC;
		end
		a_in = (left_end == '0) ? FIELD_W'(1) : left_end;
		b_in = (right_end > eff_size) ? eff_size : right_end;
		mid_sum = {1'b0, cur_q.lo} + {1'b0, cur_q.hi};
		mid = mid_sum[FIELD_W:1];
		covers = (a_q <= cur_q.lo) && (b_q >= cur_q.hi);
		lchild = {cur_q.node[AW-2:0], 1'b0};
		rchild = {cur_q.node[AW-2:0], 1'b1};
		top = stk_q[sp_q[SW-1:0] - SW'(1)];
	end

	assign cfg_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign in_ready   = (state_q == ST_IDLE) && !out_valid_q && !cfg_valid;
	assign out_valid  = out_valid_q;
	assign ones_count = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cfg_valid && cfg_ready) begin
					state_d = ST_CLEAR;
				end else if (in_valid && in_ready) begin
					state_d = (a_in <= b_in) ? ST_POP : ST_DONE;
				end
			end
			ST_POP: begin
				if (sp_q == '0) begin
					state_d = ST_DONE;
				end else if (top.ret) begin
					state_d = ST_SUM_RD;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ:    state_d = ST_VISIT;
			ST_VISIT:   state_d = (covers || !node_pend) ? ST_POP : ST_PUSH_RD;
			ST_PUSH_RD: state_d = ST_PUSH_WR;
			ST_PUSH_WR: state_d = cur_q.ret ? ST_POP : ST_PUSH_RD;
			ST_SUM_RD:  state_d = ST_SUM_RD2;
			ST_SUM_RD2: state_d = ST_SUM_WR;
			ST_SUM_WR:  state_d = ST_POP;
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory port.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = cur_q.node;
		mem_wdata = {ones_q, node_pend};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_POP: begin
				mem_addr = top.node;
			end
			ST_VISIT: begin
				if (covers && mode_q == MODE_FLIP) begin
					mem_we    = 1'b1;
					mem_wdata = {cur_q.hi - cur_q.lo + FIELD_W'(1) - mem_rdata[MEMW-1:1],
						!mem_rdata[0]};
				end else if (!covers && node_pend == 1'b0) begin
					mem_we = 1'b0;
				end else if (!covers) begin
					mem_we    = 1'b1;
					mem_wdata = {mem_rdata[MEMW-1:1], 1'b0};
				end
			end
			ST_PUSH_RD: begin
				mem_addr = cur_q.ret ? rchild : lchild;
			end
			ST_PUSH_WR: begin
				mem_we   = 1'b1;
				mem_addr = cur_q.ret ? rchild : lchild;
				mem_wdata = cur_q.ret
					? {cur_q.hi - mid - mem_rdata[MEMW-1:1], !mem_rdata[0]}
					: {mid - cur_q.lo + FIELD_W'(1) - mem_rdata[MEMW-1:1], !mem_rdata[0]};
			end
			ST_SUM_RD: begin
				mem_addr = lchild;
			end
			ST_SUM_RD2: begin
				mem_addr = rchild;
			end
			ST_SUM_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {lsum_q + mem_rdata[MEMW-1:1], 1'b0};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// The visit reads the node's pending mark straight from the memory port.
	assign node_pend = (state_q == ST_VISIT) ? mem_rdata[0] : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= SIZE_RESET;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					clr_q <= '0;
					if (cfg_valid && cfg_ready) begin
						size_q <= active_size;
					end else if (in_valid && in_ready) begin
						mode_q  <= mode;
						a_q     <= a_in;
						b_q     <= b_in;
						acc_q   <= '0;
						stk_q[0] <= '{node: AW'(1), lo: FIELD_W'(1), hi: eff_size, ret: 1'b0};
						sp_q    <= SW'(1);
					end
				end
				ST_POP: begin
					if (sp_q != '0) begin
						cur_q <= top;
						sp_q  <= sp_q - SW'(1);
					end
				end
				ST_VISIT: begin
					ones_q <= mem_rdata[MEMW-1:1];
					if (covers) begin
						if (mode_q == MODE_COUNT) begin
							acc_q <= acc_q + mem_rdata[MEMW-1:1];
						end
					end else begin
						// Push order: sum on return (flips only), right, then left; left is walked first.
						if (mode_q == MODE_FLIP) begin
							stk_q[sp_q] <= '{node: cur_q.node, lo: cur_q.lo, hi: cur_q.hi,
								ret: 1'b1};
						end
						if (b_q > mid) begin
							stk_q[sp_q + SW'(mode_q == MODE_FLIP)] <=
								'{node: rchild, lo: mid + FIELD_W'(1), hi: cur_q.hi, ret: 1'b0};
						end
						if (a_q <= mid) begin
							stk_q[sp_q + SW'(mode_q == MODE_FLIP) + SW'(b_q > mid)] <=
								'{node: lchild, lo: cur_q.lo, hi: mid, ret: 1'b0};
						end
						sp_q <= sp_q + SW'(mode_q == MODE_FLIP) + SW'(b_q > mid)
							+ SW'(a_q <= mid);
						cur_q.ret <= 1'b0;
					end
				end
				ST_PUSH_WR: begin
					cur_q.ret <= 1'b1;
				end
				ST_SUM_RD2: begin
					lsum_q <= mem_rdata[MEMW-1:1];
				end
				ST_DONE: begin
					out_valid_q <= (mode_q == MODE_COUNT);
					out_q       <= acc_q;
				end
				default: begin
				end
			endcase
		end
	end

	`RFCT_ASSERT_IMP(a_out_is_count, clk, arst_n, out_valid && !$past(out_valid),
		mode_q == MODE_COUNT, "result from a flip")
	`RFCT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in_ready,
		"accepted while busy")
	`RFCT_ASSERT_NEXT(a_cfg_clears, clk, arst_n, cfg_valid && cfg_ready,
		state_q == ST_CLEAR, "size write without clearing")
	`RFCT_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, sp_q <= SW'(LVL),
		"walk stack overflow")

endmodule

FILE: test/rfct_checker.sv
// ----------------------------------------------------------------------------
// rfct_checker
// Watches the configuration, input and output channels of the range flip
// count tree unit. It keeps a flat row of cell bits and updates it on every
// accepted beat to predict each ones count. Each result is compared with the
// oldest predicted count.
// ----------------------------------------------------------------------------
module rfct_checker
	import rfct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [FIELD_W-1:0] active_size,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               mode,
	input  logic [FIELD_W-1:0] left_end,
	input  logic [FIELD_W-1:0] right_end,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [FIELD_W-1:0] ones_count,
	output int                 fail_count,
	output int                 pending_counts
);

	logic [FIELD_W-1:0] size_reg;
	bit                 cell_bits [1:MAX_CELLS];
	logic [FIELD_W-1:0] expected_counts [$];

	// Flips or counts one range of cells and returns the count of ones.
	function automatic logic [FIELD_W-1:0] walk_range(logic m, logic [FIELD_W-1:0] a_in,
			logic [FIELD_W-1:0] b_in);
		int unsigned size;
		int unsigned a;
		int unsigned b;
		int unsigned total;
		size = size_reg;
		a = a_in;
		b = b_in;
		total = 0;
		if (size < 1) size = 1;
		if (size > MAX_CELLS) size = MAX_CELLS;
		if (a < 1) a = 1;
		if (b > size) b = size;
		for (int unsigned i = a; i <= b; i++) begin
			if (m == MODE_FLIP) cell_bits[i] = !cell_bits[i];
			else if (cell_bits[i]) total++;
		end
		return total[FIELD_W-1:0];
	endfunction

	function automatic void clear_cells();
		for (int i = 1; i <= MAX_CELLS; i++) cell_bits[i] = 1'b0;
	endfunction

	assign pending_counts = expected_counts.size();

	always @(posedge clk or negedge arst_n) begin
		logic [FIELD_W-1:0] want;
		if (!arst_n) begin
			size_reg = SIZE_RESET;
			clear_cells();
			expected_counts.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_counts.size() == 0) begin
					$error("ones_count beat with no count expected: actual %0d", ones_count);
					fail_count++;
				end else begin
					want = expected_counts.pop_front();
					if (ones_count !== want) begin
						$error("ones_count: expected %0d, actual %0d", want, ones_count);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				size_reg = active_size;
				clear_cells();
			end
			if (in_valid && in_ready) begin
				want = walk_range(mode, left_end, right_end);
				if (mode == MODE_COUNT) expected_counts = {expected_counts, want};
			end
		end
	end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives range flips and range counts into the range flip count tree unit
// over several size settings and idle patterns; the checker predicts and
// compares every count, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import rfct_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 400;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [FIELD_W-1:0] active_size;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic [FIELD_W-1:0] left_end;
	logic [FIELD_W-1:0] right_end;
	logic               out_valid;
	logic               out_ready;
	logic [FIELD_W-1:0] ones_count;
	int                 fail_count;
	int                 pending_counts;

	int                 send_idle;
	int                 recv_idle;
	bit                 hold_req;
	int                 quiet_cycles;
	int unsigned        cur_size;

	range_flip_count_tree_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .active_size(active_size),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .left_end(left_end), .right_end(right_end),
		.out_valid(out_valid), .out_ready(out_ready), .ones_count(ones_count)
	);

	rfct_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .active_size(active_size),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .left_end(left_end), .right_end(right_end),
		.out_valid(out_valid), .out_ready(out_ready), .ones_count(ones_count),
		.fail_count(fail_count), .pending_counts(pending_counts)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Cycles with no beat on any channel end the run once they reach the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_range(logic m, int unsigned a, int unsigned b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		left_end  <= a[FIELD_W-1:0];
		right_end <= b[FIELD_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_counts != 0) @(posedge clk);
		// A trailing flip gives no result, so let it finish.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(int unsigned value);
		drain();
		cfg_valid   <= 1'b1;
		active_size <= value[FIELD_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (value < 1) cur_size = 1;
		else if (value > 1024) cur_size = 1024;
		else cur_size = value;
	endtask

	task automatic random_range();
		int unsigned a;
		int unsigned b;
		int unsigned pick;
		logic        m;
		m = ($urandom_range(99) < 55);
		pick = $urandom_range(99);
		if (pick < 80) begin
			a = $urandom_range(cur_size, 1);
			b = $urandom_range(cur_size, a);
		end else if (pick < 90) begin
			a = $urandom_range(2047);
			b = $urandom_range(2047);
		end else begin
			a = $urandom_range(2) == 0 ? 0 : $urandom_range(cur_size, 1);
			b = $urandom_range(2047, cur_size);
		end
		send_range(m, a, b);
	endtask

	initial begin
		int unsigned sizes [6];
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		active_size <= SIZE_RESET;
		in_valid    <= 1'b0;
		mode        <= MODE_FLIP;
		left_end    <= '0;
		right_end   <= '0;
		send_idle   = 0;
		recv_idle   = 0;
		hold_req    = 1'b0;
		cur_size    = 1024;
		sizes = '{1, 2, 0, 2047, 1024, 0};
		sizes[5] = $urandom_range(1000, 3);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed checks at the reset size.
		send_range(MODE_COUNT, 1, 1024);
		send_range(MODE_FLIP, 1, 1024);
		send_range(MODE_COUNT, 1, 1024);
		send_range(MODE_COUNT, 1, 1);
		send_range(MODE_FLIP, 0, 0);
		send_range(MODE_COUNT, 0, 2);
		send_range(MODE_FLIP, 5, 3);
		send_range(MODE_COUNT, 5, 3);
		send_range(MODE_COUNT, 1000, 2047);
		send_range(MODE_FLIP, 512, 513);
		send_range(MODE_COUNT, 500, 520);
		send_range(MODE_COUNT, 2047, 2047);
		send_range(MODE_FLIP, 1024, 1024);
		send_range(MODE_COUNT, 1023, 1024);
		send_range(MODE_FLIP, 1365, 682);
		send_range(MODE_FLIP, 682, 1365);
		send_range(MODE_COUNT, 1, 2047);
		send_range(MODE_COUNT, 1024, 1);

		for (int p = 0; p < 6; p++) begin
			write_size(sizes[p]);
			if (p < 2) begin
				send_idle = 31;
				recv_idle = 51;
			end else if (p < 4) begin
				send_idle = 51;
				recv_idle = 31;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int i = 0; i < 140; i++) begin
				if (p == 1 && i == 40) hold_req = 1'b1;
				if (p == 3 && i == 70) drain();
				random_range();
			end
		end

		drain();
		if (fail_count == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end

endmodule
